>>> rtl/core/cmf_pkg.sv
// ----------------------------------------------------------------------------
// cmf_pkg
// Shared types, constants and arithmetic helpers for the clustered MF block.
// ----------------------------------------------------------------------------
package cmf_pkg;

  localparam int LATENT_DIM_DEF   = 16;
  localparam int NUM_CLUSTERS_DEF = 4;
  localparam int USER_ROWS_DEF    = 1024;
  localparam int ITEM_ROWS_DEF    = 1024;

  localparam logic [15:0] LR_RESET  = 16'd655;
  localparam logic [15:0] REG_RESET = 16'd655;

  typedef enum logic [1:0] {
    OP_TRAIN   = 2'd0,
    OP_WR_USER = 2'd1,
    OP_WR_ITEM = 2'd2,
    OP_PREDICT = 2'd3
  } op_t;

  localparam logic REG_LR  = 1'b0;
  localparam logic REG_REG = 1'b1;

  typedef struct packed {
    logic [1:0]         operation;
    logic [1:0]         cluster;
    logic [9:0]         user_index;
    logic [9:0]         item_index;
    logic [3:0]         dim_index;
    logic signed [31:0] value;
  } cmf_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               skipped;
  } cmf_out_t;

  // Operand routing for the shared multiply unit.
  typedef enum logic [1:0] {
    MUL_DOT = 2'd0,
    MUL_ERR = 2'd1,
    MUL_REG = 2'd2,
    MUL_LR  = 2'd3
  } mul_sel_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7fffffff;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

>>> rtl/core/cmf_ram.sv
// ----------------------------------------------------------------------------
// cmf_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module cmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> rtl/core/cmf_mul.sv
// ----------------------------------------------------------------------------
// cmf_mul
// Shared 33x33 signed multiplier, registered, floor shift by 16 after it.
// ----------------------------------------------------------------------------
module cmf_mul (
  input  logic                clk,
  input  logic signed [32:0]  a,
  input  logic signed [32:0]  b,
  output logic signed [49:0]  prod_q
);
  logic signed [65:0] prod;

  assign prod = a * b;

  // Arithmetic right shift floors toward minus infinity.
  always_ff @(posedge clk) begin
    prod_q <= prod[65:16];
  end
endmodule

>>> rtl/core/clustered_mf_sgd_update_top.sv
// ----------------------------------------------------------------------------
// clustered_mf_sgd_update_top
// Per-cluster user/item factor tables with SGD training and prediction.
// ----------------------------------------------------------------------------
// Channel  | Ports                               | Handshake
// ---------+-------------------------------------+------------------------------
// command  | start, busy, in_data (cmf_in_t)     | taken when start && !busy
// result   | done, out_data (cmf_out_t)          | one cycle strobe, no stall
// config   | psel penable pwrite paddr pwdata .. | APB, pready tied high
//
// The single shared multiplier and the one port of each factor RAM serialize the
// work: the dot pass steps each element through address, RAM wait, product and
// accumulate states; the update pass reads u_k and v_k, then forms the error,
// regularization, gradient and step products and writes back, per table in turn.
// Reset idles the sequencer, clears done and loads the config defaults; the
// datapath registers and tables are not cleared. The receiver cannot stall: done pulses for one cycle per transaction.
// ----------------------------------------------------------------------------
module clustered_mf_sgd_update_top #(
  parameter int LATENT_DIM   = cmf_pkg::LATENT_DIM_DEF,
  parameter int NUM_CLUSTERS = cmf_pkg::NUM_CLUSTERS_DEF,
  parameter int USER_ROWS    = cmf_pkg::USER_ROWS_DEF,
  parameter int ITEM_ROWS    = cmf_pkg::ITEM_ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cmf_pkg::cmf_in_t in_data,
  output logic             done,
  output cmf_pkg::cmf_out_t out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import cmf_pkg::*;

  localparam int DW = (LATENT_DIM > 1) ? $clog2(LATENT_DIM) : 1;
  localparam int CW = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
  localparam int UW = (USER_ROWS > 1) ? $clog2(USER_ROWS) : 1;
  localparam int IW = (ITEM_ROWS > 1) ? $clog2(ITEM_ROWS) : 1;
  localparam int UDEPTH = NUM_CLUSTERS * USER_ROWS * LATENT_DIM;
  localparam int IDEPTH = NUM_CLUSTERS * ITEM_ROWS * LATENT_DIM;
  localparam int UAW = $clog2(UDEPTH);
  localparam int IAW = $clog2(IDEPTH);
  localparam int KW = $clog2(LATENT_DIM + 1);

  // Sequencer states (one-hot).
  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_DRD   = 14'b00000000000010, // dot: address element k
    S_DWAIT = 14'b00000000000100, // dot: RAM data back
    S_DMUL  = 14'b00000000001000, // dot: product register valid
    S_DACC  = 14'b00000000010000,
    S_URD   = 14'b00000000100000, // update: read u_k, v_k
    S_UWAIT = 14'b00000001000000,
    S_EMUL  = 14'b00000010000000, // err*b
    S_RMUL  = 14'b00000100000000, // reg*a
    S_GRAD  = 14'b00001000000000, // register saturated gradient
    S_LMUL  = 14'b00010000000000, // lr*g
    S_WB    = 14'b00100000000000, // write back
    S_FIN   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  // ---------------- configuration ----------------
  logic [15:0] step_rate, reg_strength;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_rate    <= LR_RESET;
      reg_strength <= REG_RESET;
    end else if (cfg_we && paddr[1:0] == 2'b00) begin
      // Hold unknown indexes: only registers 0 and 1 exist.
      if (paddr[2] == REG_LR) step_rate <= pwdata[15:0];
      else if (paddr[2] == REG_REG) reg_strength <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_LR) prdata = {16'd0, step_rate};
      else prdata = {16'd0, reg_strength};
    end
  end

  // ---------------- latched command ----------------
  cmf_in_t            cmd;
  logic [UAW-1:0]     ubase;
  logic [IAW-1:0]     ibase;
  logic [KW-1:0]      k;
  logic               pass2;      // update: 0 = user element, 1 = item element
  logic signed [63:0] sum;
  logic signed [31:0] err;
  logic signed [31:0] u_q, v_q, un_q;
  logic signed [49:0] e_q;
  logic signed [31:0] g_q;
  logic signed [31:0] res;
  logic               skip;

  logic               accept;
  logic               rows_ok;
  logic               user_ok, item_ok, dim_ok;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  assign user_ok = (32'(in_data.cluster) < NUM_CLUSTERS) &&
                   (32'(in_data.user_index) < USER_ROWS);
  assign item_ok = (32'(in_data.cluster) < NUM_CLUSTERS) &&
                   (32'(in_data.item_index) < ITEM_ROWS);
  assign dim_ok  = 32'(in_data.dim_index) < LATENT_DIM;
  assign rows_ok = user_ok && item_ok;

  // ---------------- RAMs ----------------
  logic           u_we, i_we;
  logic [UAW-1:0] u_addr;
  logic [IAW-1:0] i_addr;
  logic [31:0]    u_wdata, i_wdata, u_rdata, i_rdata;

  cmf_ram #(.WIDTH(32), .DEPTH(UDEPTH)) u_user_ram (
    .clk(clk), .we(u_we), .addr(u_addr), .wdata(u_wdata), .rdata(u_rdata));
  cmf_ram #(.WIDTH(32), .DEPTH(IDEPTH)) u_item_ram (
    .clk(clk), .we(i_we), .addr(i_addr), .wdata(i_wdata), .rdata(i_rdata));

  logic [UAW-1:0] wr_uaddr;
  logic [IAW-1:0] wr_iaddr;
  logic [DW-1:0]  kidx;

  assign wr_uaddr = UAW'((64'(in_data.cluster[CW-1:0]) * USER_ROWS +
                          64'(in_data.user_index[UW-1:0])) * LATENT_DIM +
                         64'(in_data.dim_index[DW-1:0]));
  assign wr_iaddr = IAW'((64'(in_data.cluster[CW-1:0]) * ITEM_ROWS +
                          64'(in_data.item_index[IW-1:0])) * LATENT_DIM +
                         64'(in_data.dim_index[DW-1:0]));
  assign kidx = k[DW-1:0];

  // ---------------- shared multiplier ----------------
  mul_sel_t           msel;
  logic signed [32:0] ma, mb;
  logic signed [49:0] mp;

  cmf_mul u_mul (.clk(clk), .a(ma), .b(mb), .prod_q(mp));

  logic signed [31:0] a_el, b_el;   // element updated and its partner
  assign a_el = pass2 ? v_q : u_q;
  assign b_el = pass2 ? un_q : v_q;

  always_comb begin
    unique case (msel)
      MUL_DOT: begin ma = 33'(signed'(u_rdata)); mb = 33'(signed'(i_rdata)); end
      MUL_ERR: begin ma = 33'(err);              mb = 33'(b_el);            end
      MUL_REG: begin ma = 33'({1'b0, reg_strength}); mb = 33'(a_el);        end
      default: begin ma = 33'({1'b0, step_rate}); mb = 33'(g_q);            end
    endcase
  end

  // Gradient and updated element from registered products.
  logic signed [63:0] g_full, a_full;
  logic signed [31:0] g_sat, a_new;
  assign g_full = 64'(e_q) * 2 - 64'(mp);
  assign g_sat  = sat32(g_full);
  assign a_full = 64'(a_el) + 64'(mp);
  assign a_new  = sat32(a_full);

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    msel = MUL_DOT;
    u_we = 1'b0; i_we = 1'b0;
    u_addr = ubase + UAW'(kidx);
    i_addr = ibase + IAW'(kidx);
    u_wdata = a_new; i_wdata = a_new;
    unique case (state)
      S_IDLE: begin
        u_addr = wr_uaddr; i_addr = wr_iaddr;
        u_wdata = in_data.value; i_wdata = in_data.value;
        if (accept) begin
          u_we = (in_data.operation == OP_WR_USER) && user_ok && dim_ok;
          i_we = (in_data.operation == OP_WR_ITEM) && item_ok && dim_ok;
          if ((in_data.operation == OP_TRAIN || in_data.operation == OP_PREDICT)
              && rows_ok && !(in_data.operation == OP_TRAIN && in_data.value == 0))
            state_next = S_DRD;
          else
            state_next = S_OUT;
        end
      end
      S_DRD:   state_next = S_DWAIT;
      S_DWAIT: begin msel = MUL_DOT; state_next = S_DMUL; end
      S_DMUL:  state_next = S_DACC;
      S_DACC:  state_next = (32'(k) + 1 == LATENT_DIM) ? S_FIN : S_DRD;
      S_FIN:   state_next = (cmd.operation == OP_PREDICT) ? S_OUT : S_URD;
      S_URD:   state_next = S_UWAIT;
      S_UWAIT: state_next = S_EMUL;
      S_EMUL:  begin msel = MUL_ERR; state_next = S_RMUL; end
      S_RMUL:  begin msel = MUL_REG; state_next = S_GRAD; end
      S_GRAD:  begin msel = MUL_LR;  state_next = S_LMUL; end
      S_LMUL:  begin msel = MUL_LR;  state_next = S_WB;   end
      S_WB: begin
        msel = MUL_LR;
        if (!pass2) begin
          u_we = 1'b1;
          state_next = S_EMUL;
        end else begin
          i_we = 1'b1;
          state_next = (32'(k) + 1 == LATENT_DIM) ? S_OUT : S_URD;
        end
      end
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_OUT);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd   <= in_data;
          ubase <= UAW'((64'(in_data.cluster[CW-1:0]) * USER_ROWS +
                         64'(in_data.user_index[UW-1:0])) * LATENT_DIM);
          ibase <= IAW'((64'(in_data.cluster[CW-1:0]) * ITEM_ROWS +
                         64'(in_data.item_index[IW-1:0])) * LATENT_DIM);
          k     <= '0;
          sum   <= '0;
          pass2 <= 1'b0;
          res   <= '0;
          skip  <= (in_data.operation == OP_TRAIN) && rows_ok && (in_data.value == 0);
        end
      end
      S_DACC: begin
        sum <= sum + 64'(mp);
        k   <= k + KW'(1);
      end
      S_FIN: begin
        k <= '0;
        if (cmd.operation == OP_PREDICT) res <= sat32(sum);
        else begin
          err <= sat32(64'(cmd.value) - sum);
          res <= sat32(64'(cmd.value) - sum);
        end
      end
      S_UWAIT: begin
        u_q   <= u_rdata;
        v_q   <= i_rdata;
        pass2 <= 1'b0;
      end
      S_RMUL:  e_q <= mp;
      S_GRAD:  g_q <= g_sat;
      S_WB: begin
        if (!pass2) begin
          un_q  <= a_new;
          pass2 <= 1'b1;
        end else begin
          k <= k + KW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      out_data.result_value <= res;
      out_data.skipped      <= skip;
    end
  end

`ifndef ASSERT_OFF
  // A result appears only after a sequence step through the output state.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_OUT) else $error("done without output state");
  // Every accepted command leaves idle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("accepted command did not start");
  // Only one table is written in any cycle.
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(u_we && i_we)) else $error("both tables written at once");
  // A skipped result always carries a zero value.
  a_skip_train: assert property (@(posedge clk) disable iff (rst)
    (done && out_data.skipped) |-> out_data.result_value == 0)
    else $error("skipped result carries a value");
`endif

endmodule
